@@ src/clhg_pkg.sv @@
// shared types, constants and register codes of the cpu load hotplug governor
package clhg_pkg;

  localparam int MAX_CORES_DEF = 8;

  // datapath width of the shared unit: holds ten times a 64-bit remainder
  localparam int AW = 68;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 8;
  localparam int ACC_W   = 10;
  localparam int SEEN_W  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_LIMIT  = 3'd0,
    REG_BUSY_LIMIT  = 3'd1,
    REG_SURGE_LIMIT = 3'd2,
    REG_SURGE_STEP  = 3'd3,
    REG_OFF_ROUNDS  = 3'd4,
    REG_ON_ROUNDS   = 3'd5
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = 7'd4;
  localparam logic [LIMIT_W-1:0] BUSY_LIMIT_RST  = 7'd70;
  localparam logic [LIMIT_W-1:0] SURGE_LIMIT_RST = 7'd95;
  localparam logic [COUNT_W-1:0] SURGE_STEP_RST  = 8'd5;
  localparam logic [COUNT_W-1:0] OFF_ROUNDS_RST  = 8'd10;
  localparam logic [COUNT_W-1:0] ON_ROUNDS_RST   = 8'd5;

  localparam logic [ACC_W-1:0]   ACC_MAX   = 10'd1023;
  localparam logic [SEEN_W-1:0]  SEEN_MAX  = 7'd127;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_OFFLINE = 2'd1,
    ACT_ONLINE  = 2'd2
  } action_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic          sub;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] res;
    logic          carry;
  } alu_rsp_t;

endpackage

@@ src/clhg_if.sv @@
// valid/ready channels for core samples and governor results
interface clhg_sample_if;
  logic        valid;
  logic        ready;
  logic [2:0]  core_index;
  logic [63:0] idle_total;
  logic [63:0] time_total;
  logic        round_end;

  modport source (output valid, core_index, idle_total, time_total, round_end, input ready);
  modport sink (input valid, core_index, idle_total, time_total, round_end, output ready);
endinterface

interface clhg_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] average_load;
  logic [1:0] hotplug_action;

  modport source (output valid, average_load, hotplug_action, input ready);
  modport sink (input valid, average_load, hotplug_action, output ready);
endinterface

@@ src/cpu_load_hotplug_governor.sv @@
// top level of the cpu load hotplug governor
//
// usage: each sample transaction carries one core's cumulative idle and wall
// time counters; the last sample of a round has round_end set. a round end
// produces one result transaction with the truncated mean percent load and
// a hotplug request (none, offline, online); other samples produce nothing.
// sample.ready is high only while the sequencer is idle; one item at a time.
// work per sample, from the accepting edge until ready is high again:
//   core out of range: no history or load update, ready again next cycle
//   unless round_end is set, which goes straight on to the round end steps
//   zero load: idle delta, time delta, busy compare and accumulate;
//   nonzero load adds two decimal digits, each one multiply-by-ten and
//   four restoring subtract steps. round end adds setup, a mean division
//   of 7 steps and the decision; the result is valid the cycle after it.
// deltas, compares, multiplies and divisions share one 68-bit add/subtract unit.
// configuration is a plain write port, to be written only while idle.
// reset (rst, synchronous) clears the per-core history, the round sums,
// the hysteresis counters and loads the register defaults.
// a stalled result holds; the next sample is still accepted, and a later
// round end waits in the decision step until the result register is free.
module cpu_load_hotplug_governor #(
  parameter int MAX_CORES = clhg_pkg::MAX_CORES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [clhg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clhg_pkg::CFG_DATA_W-1:0]  cfg_data,
  clhg_sample_if.sink                      sample,
  clhg_result_if.source                    result
);

  localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int CW    = (IDX_W > 3) ? IDX_W : 3;
  localparam int AW    = clhg_pkg::AW;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DIDLE  = 10'b0000000010,
    ST_DTIME  = 10'b0000000100,
    ST_BUSY   = 10'b0000001000,
    ST_MUL10  = 10'b0000010000,
    ST_DIV    = 10'b0000100000,
    ST_ACCUM  = 10'b0001000000,
    ST_MEAN   = 10'b0010000000,
    ST_MDIV   = 10'b0100000000,
    ST_DECIDE = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic [clhg_pkg::LIMIT_W-1:0] idle_limit, busy_limit, surge_limit;
  logic [clhg_pkg::COUNT_W-1:0] surge_step, off_rounds, on_rounds;

  // per-core history memory
  logic [63:0]          last_idle_mem [MAX_CORES];
  logic [63:0]          last_time_mem [MAX_CORES];
  logic [MAX_CORES-1:0] hist_valid;
  logic [63:0]          rd_idle, rd_time;
  logic                 rd_valid;

  // item registers
  logic [2:0]  core_q;
  logic [63:0] idle_q, time_q;
  logic        last_q;

  // working registers
  logic [63:0]    didle, den;
  logic [AW-1:0]  rem;
  logic [6:0]     quo;
  logic [2:0]     step;
  logic           lo_phase;
  logic [3:0]     hi_digit;
  logic [6:0]     load_q;
  logic [6:0]     mean_q;

  // round and hysteresis state
  logic [clhg_pkg::ACC_W-1:0]   acc;
  logic [clhg_pkg::SEEN_W-1:0]  cores;
  logic [clhg_pkg::COUNT_W-1:0] idle_rounds, busy_score;

  // result register
  logic                 out_valid;
  logic [6:0]           out_mean;
  clhg_pkg::action_t    out_action;

  clhg_pkg::alu_req_t alu_req;
  clhg_pkg::alu_rsp_t alu_rsp;

  clhg_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  logic [CW-1:0]    core_ext_in, core_ext_q;
  logic [IDX_W-1:0] idx_in, idx_q;
  logic             accept, out_free, in_range;
  logic [63:0]      last_idle_eff, last_time_eff;
  logic [6:0]       quo_new;
  logic [6:0]       load_calc;
  logic [clhg_pkg::ACC_W:0] acc_sum;

  assign core_ext_in = CW'(sample.core_index);
  assign core_ext_q  = CW'(core_q);
  assign idx_in      = core_ext_in[IDX_W-1:0];
  assign idx_q       = core_ext_q[IDX_W-1:0];
  assign in_range    = int'(sample.core_index) < MAX_CORES;

  assign sample.ready = (state == ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;

  assign result.valid          = out_valid;
  assign result.average_load   = out_mean;
  assign result.hotplug_action = out_action;

  assign last_idle_eff = rd_valid ? rd_idle : 64'd0;
  assign last_time_eff = rd_valid ? rd_time : 64'd0;

  assign quo_new   = quo | (alu_rsp.carry ? (7'd1 << step) : 7'd0);
  assign load_calc = 7'({hi_digit, 3'b000}) + 7'({hi_digit, 1'b0}) + 7'(quo_new[3:0]);
  assign acc_sum   = {1'b0, acc} + (clhg_pkg::ACC_W+1)'(load_q);

  // shared unit operand selection
  always_comb begin
    alu_req = '0;
    unique case (state)
      ST_DIDLE: begin
        alu_req.a   = AW'(idle_q);
        alu_req.b   = AW'(last_idle_eff);
        alu_req.sub = 1'b1;
      end
      ST_DTIME: begin
        alu_req.a   = AW'(time_q);
        alu_req.b   = AW'(last_time_eff);
        alu_req.sub = 1'b1;
      end
      ST_BUSY: begin
        alu_req.a   = AW'(den);
        alu_req.b   = AW'(didle);
        alu_req.sub = 1'b1;
      end
      ST_MUL10: begin
        alu_req.a   = rem << 3;
        alu_req.b   = rem << 1;
        alu_req.sub = 1'b0;
      end
      ST_DIV: begin
        alu_req.a   = rem;
        alu_req.b   = AW'(den) << step;
        alu_req.sub = 1'b1;
      end
      ST_MDIV: begin
        alu_req.a   = rem;
        alu_req.b   = AW'(cores) << step;
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  // hysteresis decision for the round end
  logic [clhg_pkg::COUNT_W-1:0] ir_upd, bs_upd, ir_next, bs_next;
  logic [clhg_pkg::COUNT_W:0]   bs_surge;
  clhg_pkg::action_t            action_next;

  always_comb begin
    bs_surge = {1'b0, busy_score} + {1'b0, surge_step};
    ir_upd   = idle_rounds;
    bs_upd   = busy_score;
    if (mean_q <= idle_limit) begin
      ir_upd = (idle_rounds == clhg_pkg::COUNT_MAX) ? idle_rounds : idle_rounds + 8'd1;
      bs_upd = '0;
    end else if (mean_q > surge_limit) begin
      ir_upd = '0;
      bs_upd = bs_surge[clhg_pkg::COUNT_W] ? clhg_pkg::COUNT_MAX
                                           : bs_surge[clhg_pkg::COUNT_W-1:0];
    end else if (mean_q > busy_limit) begin
      ir_upd = '0;
      bs_upd = (busy_score == clhg_pkg::COUNT_MAX) ? busy_score : busy_score + 8'd1;
    end
    ir_next     = ir_upd;
    bs_next     = bs_upd;
    action_next = clhg_pkg::ACT_NONE;
    if (ir_upd >= off_rounds) begin
      ir_next     = '0;
      action_next = clhg_pkg::ACT_OFFLINE;
    end
    if (bs_upd >= on_rounds) begin
      bs_next     = '0;
      action_next = clhg_pkg::ACT_ONLINE;
    end
  end

  // history memory, read on accept and written once the deltas are taken
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idle <= last_idle_mem[idx_in];
      rd_time <= last_time_mem[idx_in];
    end
    if (state == ST_DTIME) begin
      last_idle_mem[idx_q] <= idle_q;
      last_time_mem[idx_q] <= time_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit  <= clhg_pkg::IDLE_LIMIT_RST;
      busy_limit  <= clhg_pkg::BUSY_LIMIT_RST;
      surge_limit <= clhg_pkg::SURGE_LIMIT_RST;
      surge_step  <= clhg_pkg::SURGE_STEP_RST;
      off_rounds  <= clhg_pkg::OFF_ROUNDS_RST;
      on_rounds   <= clhg_pkg::ON_ROUNDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clhg_pkg::REG_IDLE_LIMIT:  idle_limit  <= cfg_data[clhg_pkg::LIMIT_W-1:0];
        clhg_pkg::REG_BUSY_LIMIT:  busy_limit  <= cfg_data[clhg_pkg::LIMIT_W-1:0];
        clhg_pkg::REG_SURGE_LIMIT: surge_limit <= cfg_data[clhg_pkg::LIMIT_W-1:0];
        clhg_pkg::REG_SURGE_STEP:  surge_step  <= cfg_data;
        clhg_pkg::REG_OFF_ROUNDS:  off_rounds  <= cfg_data;
        clhg_pkg::REG_ON_ROUNDS:   on_rounds   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      hist_valid  <= '0;
      acc         <= '0;
      cores       <= '0;
      idle_rounds <= '0;
      busy_score  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // the decision step reloads the result register itself
      if (out_valid && result.ready && (state != ST_DECIDE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            core_q   <= sample.core_index;
            idle_q   <= sample.idle_total;
            time_q   <= sample.time_total;
            last_q   <= sample.round_end;
            rd_valid <= hist_valid[idx_in];
            if (in_range) begin
              state <= ST_DIDLE;
            end else if (sample.round_end) begin
              state <= ST_MEAN;
            end
          end
        end
        ST_DIDLE: begin
          didle <= alu_rsp.res[63:0];
          state <= ST_DTIME;
        end
        ST_DTIME: begin
          den               <= alu_rsp.res[63:0];
          hist_valid[idx_q] <= 1'b1;
          if (cores != clhg_pkg::SEEN_MAX) begin
            cores <= cores + 7'd1;
          end
          state <= ST_BUSY;
        end
        ST_BUSY: begin
          // load counts only when the time delta exceeds the idle delta
          if (alu_rsp.carry && (alu_rsp.res != '0)) begin
            rem      <= alu_rsp.res;
            lo_phase <= 1'b0;
            state    <= ST_MUL10;
          end else begin
            load_q <= '0;
            state  <= ST_ACCUM;
          end
        end
        ST_MUL10: begin
          rem   <= alu_rsp.res;
          quo   <= '0;
          step  <= 3'd3;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (alu_rsp.carry) begin
            rem <= alu_rsp.res;
          end
          quo <= quo_new;
          if (step == 3'd0) begin
            if (!lo_phase) begin
              hi_digit <= quo_new[3:0];
              lo_phase <= 1'b1;
              state    <= ST_MUL10;
            end else begin
              load_q <= load_calc;
              state  <= ST_ACCUM;
            end
          end else begin
            step <= step - 3'd1;
          end
        end
        ST_ACCUM: begin
          acc   <= acc_sum[clhg_pkg::ACC_W] ? clhg_pkg::ACC_MAX : acc_sum[clhg_pkg::ACC_W-1:0];
          state <= last_q ? ST_MEAN : ST_IDLE;
        end
        ST_MEAN: begin
          if (cores == '0) begin
            mean_q <= '0;
            state  <= ST_DECIDE;
          end else begin
            rem   <= AW'(acc);
            quo   <= '0;
            step  <= 3'd6;
            state <= ST_MDIV;
          end
        end
        ST_MDIV: begin
          if (alu_rsp.carry) begin
            rem <= alu_rsp.res;
          end
          quo <= quo_new;
          if (step == 3'd0) begin
            mean_q <= quo_new;
            state  <= ST_DECIDE;
          end else begin
            step <= step - 3'd1;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_mean    <= mean_q;
            out_action  <= action_next;
            idle_rounds <= ir_next;
            busy_score  <= bs_next;
            acc         <= '0;
            cores       <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // per-core loads never exceed 100, so neither does their mean
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.average_load <= 7'd100))
    else $error("average load out of range");

  // round sums restart after every round end transaction
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && out_free) |=> (acc == '0 && cores == '0))
    else $error("round sums not cleared");

  // a fired online request leaves the busy score cleared
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && out_free && action_next == clhg_pkg::ACT_ONLINE)
      |=> (busy_score == '0 && result.hotplug_action == clhg_pkg::ACT_ONLINE))
    else $error("online request without counter clear");

  // the per-digit long division never shifts beyond its four quotient bits
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step <= 3'd3))
    else $error("digit step count overrun");
`endif

endmodule

@@ src/clhg_alu.sv @@
// shared add/subtract unit with carry out, used for the busy and division compares
module clhg_alu (
  input  clhg_pkg::alu_req_t req,
  output clhg_pkg::alu_rsp_t rsp
);

  logic [clhg_pkg::AW:0]   sum;
  logic [clhg_pkg::AW-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  // on subtract, carry high means a >= b
  assign sum = {1'b0, req.a} + {1'b0, b_op} + {{clhg_pkg::AW{1'b0}}, req.sub};
  assign rsp.res   = sum[clhg_pkg::AW-1:0];
  assign rsp.carry = sum[clhg_pkg::AW];

endmodule

@@ tb/cpu_load_hotplug_governor_test.sv @@
// self-checking testbench for the cpu load hotplug governor
module cpu_load_hotplug_governor_test;

  typedef struct packed {
    logic [6:0]        mean;
    clhg_pkg::action_t act;
  } round_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         core;
    logic [63:0]        d_idle;
    logic [63:0]        d_wall;
    logic               closing;
    logic               typed;
    logic [6:0]         mean;
    clhg_pkg::action_t  act;
    clhg_pkg::cfg_reg_t sel;
    logic [7:0]         val;
  } plan_row_t;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [clhg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [clhg_pkg::CFG_DATA_W-1:0] cfg_data;

  clhg_sample_if sample_ch ();
  clhg_result_if result_ch ();

  cpu_load_hotplug_governor dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  // predictor state
  logic [63:0] hist_idle [8];
  logic [63:0] hist_wall [8];
  logic [clhg_pkg::ACC_W-1:0] round_load_total;
  logic [clhg_pkg::SEEN_W-1:0] sample_count;
  logic [clhg_pkg::COUNT_W-1:0] idle_streak;
  logic [clhg_pkg::COUNT_W-1:0] busy_level;
  logic [clhg_pkg::LIMIT_W-1:0] lim_idle;
  logic [clhg_pkg::LIMIT_W-1:0] lim_busy;
  logic [clhg_pkg::LIMIT_W-1:0] lim_surge;
  logic [clhg_pkg::COUNT_W-1:0] step_surge;
  logic [clhg_pkg::COUNT_W-1:0] need_off;
  logic [clhg_pkg::COUNT_W-1:0] need_on;

  round_result_t pending_rounds [$];
  round_result_t head_result;
  plan_row_t plan [$];

  int fail_count = 0;
  int samples_sent = 0;
  int rounds_checked = 0;
  int offline_seen = 0;
  int online_seen = 0;
  int settings_done = 0;
  int gap_odds = 6;
  int stall_odds = 6;
  bit hold_request = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("%0t timeout with %0d round results outstanding", $time, pending_rounds.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [6:0] core_load(logic [63:0] d_idle, logic [63:0] d_wall);
    logic [71:0] scaled;
    logic [71:0] quot;
    if (d_wall <= d_idle) return 7'd0;
    scaled = {8'd0, d_wall - d_idle} * 72'd100;
    quot = scaled / {8'd0, d_wall};
    return quot[6:0];
  endfunction

  task automatic reset_model();
    for (int i = 0; i < 8; i++) begin
      hist_idle[i] = '0;
      hist_wall[i] = '0;
    end
    round_load_total = '0;
    sample_count = '0;
    idle_streak = '0;
    busy_level = '0;
    lim_idle = clhg_pkg::IDLE_LIMIT_RST;
    lim_busy = clhg_pkg::BUSY_LIMIT_RST;
    lim_surge = clhg_pkg::SURGE_LIMIT_RST;
    step_surge = clhg_pkg::SURGE_STEP_RST;
    need_off = clhg_pkg::OFF_ROUNDS_RST;
    need_on = clhg_pkg::ON_ROUNDS_RST;
  endtask

  task automatic track_sample(input logic [2:0] core, input logic [63:0] idle_v,
                              input logic [63:0] wall_v, input logic closing,
                              output logic has, output round_result_t res);
    logic [6:0] load;
    logic [clhg_pkg::ACC_W:0] sum;
    logic [clhg_pkg::ACC_W-1:0] quot;
    logic [clhg_pkg::COUNT_W:0] grown;
    logic go_off;
    logic go_on;
    load = core_load(idle_v - hist_idle[core], wall_v - hist_wall[core]);
    sum = {1'b0, round_load_total} + load;
    round_load_total = (sum > clhg_pkg::ACC_MAX) ? clhg_pkg::ACC_MAX
                                                 : sum[clhg_pkg::ACC_W-1:0];
    if (sample_count != clhg_pkg::SEEN_MAX) sample_count = sample_count + 1'b1;
    hist_idle[core] = idle_v;
    hist_wall[core] = wall_v;
    has = closing;
    res = '0;
    if (!closing) return;

    quot = (sample_count == 0) ? '0 : round_load_total / sample_count;
    res.mean = quot[6:0];
    round_load_total = '0;
    sample_count = '0;

    // limits checked idle first, then surge, then busy
    if (res.mean <= lim_idle) begin
      idle_streak = (idle_streak == clhg_pkg::COUNT_MAX) ? clhg_pkg::COUNT_MAX
                                                         : idle_streak + 1'b1;
      busy_level = '0;
    end else if (res.mean > lim_surge) begin
      idle_streak = '0;
      grown = {1'b0, busy_level} + step_surge;
      busy_level = (grown > clhg_pkg::COUNT_MAX) ? clhg_pkg::COUNT_MAX
                                                 : grown[clhg_pkg::COUNT_W-1:0];
    end else if (res.mean > lim_busy) begin
      idle_streak = '0;
      busy_level = (busy_level == clhg_pkg::COUNT_MAX) ? clhg_pkg::COUNT_MAX
                                                       : busy_level + 1'b1;
    end

    go_off = idle_streak >= need_off;
    go_on = busy_level >= need_on;
    res.act = clhg_pkg::ACT_NONE;
    if (go_off) begin
      idle_streak = '0;
      res.act = clhg_pkg::ACT_OFFLINE;
    end
    // online wins when both fire
    if (go_on) begin
      busy_level = '0;
      res.act = clhg_pkg::ACT_ONLINE;
    end
  endtask

  task automatic offer_sample(input logic [2:0] core, input logic [63:0] idle_v,
                              input logic [63:0] wall_v, input logic closing,
                              input logic typed, input round_result_t want);
    int gap;
    logic has;
    round_result_t got;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid <= 1'b1;
    sample_ch.core_index <= core;
    sample_ch.idle_total <= idle_v;
    sample_ch.time_total <= wall_v;
    sample_ch.round_end <= closing;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    track_sample(core, idle_v, wall_v, closing, has, got);
    samples_sent++;
    if (has) pending_rounds.push_back(typed ? want : got);
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input clhg_pkg::cfg_reg_t sel, input logic [7:0] val);
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_rounds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      clhg_pkg::REG_IDLE_LIMIT:  lim_idle = val[clhg_pkg::LIMIT_W-1:0];
      clhg_pkg::REG_BUSY_LIMIT:  lim_busy = val[clhg_pkg::LIMIT_W-1:0];
      clhg_pkg::REG_SURGE_LIMIT: lim_surge = val[clhg_pkg::LIMIT_W-1:0];
      clhg_pkg::REG_SURGE_STEP:  step_surge = val;
      clhg_pkg::REG_OFF_ROUNDS:  need_off = val;
      clhg_pkg::REG_ON_ROUNDS:   need_on = val;
      default: ;
    endcase
    settings_done++;
  endtask

  task automatic set_governor(input int idle_l, input int busy_l, input int surge_l,
                              input int step, input int off_n, input int on_n);
    write_reg(clhg_pkg::REG_IDLE_LIMIT, 8'(idle_l));
    write_reg(clhg_pkg::REG_BUSY_LIMIT, 8'(busy_l));
    write_reg(clhg_pkg::REG_SURGE_LIMIT, 8'(surge_l));
    write_reg(clhg_pkg::REG_SURGE_STEP, 8'(step));
    write_reg(clhg_pkg::REG_OFF_ROUNDS, 8'(off_n));
    write_reg(clhg_pkg::REG_ON_ROUNDS, 8'(on_n));
  endtask

  task automatic add_sample(input logic [2:0] core, input logic [63:0] d_idle,
                            input logic [63:0] d_wall, input logic closing,
                            input logic typed, input logic [6:0] mean,
                            input clhg_pkg::action_t act);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.core = core;
    row.d_idle = d_idle;
    row.d_wall = d_wall;
    row.closing = closing;
    row.typed = typed;
    row.mean = mean;
    row.act = act;
    plan.push_back(row);
  endtask

  task automatic add_write(input clhg_pkg::cfg_reg_t sel, input logic [7:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.sel = sel;
    row.val = val;
    plan.push_back(row);
  endtask

  task automatic play_rounds(input int n_items, input bit long_round);
    int sent;
    int members;
    int pct;
    int pk;
    int k;
    bit long_left;
    logic [2:0] core;
    logic [2:0] start;
    logic [63:0] span;
    logic [63:0] busy;
    logic [63:0] d_idle;
    logic closing;
    sent = 0;
    long_left = long_round;
    while (sent < n_items) begin
      if ($urandom_range(0, 14) == 0) begin
        // stray sample with arbitrary counters
        offer_sample(3'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                     $urandom_range(0, 3) == 0, 1'b0, '0);
        sent++;
      end else begin
        members = long_left ? 130 : $urandom_range(1, 8);
        long_left = 1'b0;
        case ($urandom_range(0, 3))
          0: pct = $urandom_range(0, lim_idle);
          1: pct = (lim_busy >= 100) ? 100 : $urandom_range(lim_busy + 1, 100);
          2: pct = (lim_surge >= 100) ? 100 : $urandom_range(lim_surge + 1, 100);
          default: pct = $urandom_range(0, 100);
        endcase
        start = 3'($urandom_range(0, 7));
        for (k = 0; k < members; k++) begin
          core = start + k[2:0];
          pk = pct + int'($urandom_range(0, 6)) - 3;
          if (pk < 0) pk = 0;
          if (pk > 100) pk = 100;
          if ($urandom_range(0, 9) == 0) span = {$urandom, $urandom};
          else span = 64'($urandom_range(1, 100000));
          busy = (span < 64'd1000000) ? span * 64'(pk) / 64'd100
                                      : span / 64'd100 * 64'(pk);
          d_idle = span - busy;
          case ($urandom_range(0, 29))
            0: d_idle = span + 64'($urandom_range(1, 1000));
            1: span = '0;
            default: ;
          endcase
          // now and then a short round is cut off by an early round end
          closing = (k == members - 1) || (members <= 8 && $urandom_range(0, 39) == 0);
          offer_sample(core, hist_idle[core] + d_idle, hist_wall[core] + span, closing,
                       1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(1, 15) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_rounds.size() == 0) begin
        $display("%0t unexpected result: expected none, actual load %0d action %0d", $time,
                 result_ch.average_load, result_ch.hotplug_action);
        fail_count++;
      end else begin
        head_result = pending_rounds.pop_front();
        if (result_ch.average_load !== head_result.mean) begin
          $display("%0t average_load mismatch: expected %0d actual %0d", $time,
                   head_result.mean, result_ch.average_load);
          fail_count++;
        end
        if (result_ch.hotplug_action !== head_result.act) begin
          $display("%0t hotplug_action mismatch: expected %0d actual %0d", $time,
                   head_result.act, result_ch.hotplug_action);
          fail_count++;
        end
        rounds_checked++;
        if (head_result.act == clhg_pkg::ACT_OFFLINE) offline_seen++;
        if (head_result.act == clhg_pkg::ACT_ONLINE) online_seen++;
      end
    end
  end

  initial begin
    plan_row_t row;
    round_result_t want;
    int guard;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = clhg_pkg::REG_IDLE_LIMIT;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.core_index = '0;
    sample_ch.idle_total = '0;
    sample_ch.time_total = '0;
    sample_ch.round_end = 1'b0;
    reset_model();

    // directed rows: counter deltas per core against the previous sample
    add_sample(3'd0, 64'd0, 64'd0, 1'b1, 1'b1, 7'd0, clhg_pkg::ACT_NONE);
    add_sample(3'd1, 64'd0, ALL_ONES, 1'b0, 1'b0, 7'd0, clhg_pkg::ACT_NONE);
    add_sample(3'd2, ALL_ONES, ALL_ONES, 1'b1, 1'b1, 7'd50, clhg_pkg::ACT_NONE);
    // idle delta larger than the wrapped wall delta
    add_sample(3'd1, 64'd5, 64'd4, 1'b1, 1'b1, 7'd0, clhg_pkg::ACT_NONE);
    add_sample(3'd3, 64'd1, 64'd3, 1'b1, 1'b0, 7'd0, clhg_pkg::ACT_NONE);
    add_sample(3'd4, 64'd0, 64'd100, 1'b1, 1'b1, 7'd100, clhg_pkg::ACT_ONLINE);
    add_sample(3'd5, 64'd20, 64'd100, 1'b1, 1'b1, 7'd80, clhg_pkg::ACT_NONE);
    add_sample(3'd6, 64'd1, ALL_ONES, 1'b1, 1'b0, 7'd0, clhg_pkg::ACT_NONE);
    // eleven full-load samples saturate the load sum
    for (int i = 0; i < 11; i++)
      add_sample(i[2:0], 64'd0, 64'd10, i == 10, 1'b0, 7'd0, clhg_pkg::ACT_NONE);
    // both thresholds met in one round
    add_write(clhg_pkg::REG_OFF_ROUNDS, 8'd1);
    add_write(clhg_pkg::REG_ON_ROUNDS, 8'd0);
    add_sample(3'd7, 64'd10, 64'd10, 1'b1, 1'b1, 7'd0, clhg_pkg::ACT_ONLINE);
    add_write(clhg_pkg::REG_ON_ROUNDS, 8'd5);
    add_sample(3'd0, 64'd0, 64'd0, 1'b1, 1'b1, 7'd0, clhg_pkg::ACT_OFFLINE);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.sel, row.val);
      end else begin
        want.mean = row.mean;
        want.act = row.act;
        offer_sample(row.core, hist_idle[row.core] + row.d_idle,
                     hist_wall[row.core] + row.d_wall, row.closing, row.typed, want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_governor(0, 0, 0, 0, 1, 1);
        1: set_governor(100, 100, 100, 255, 255, 255);
        2: set_governor(int'(clhg_pkg::IDLE_LIMIT_RST), int'(clhg_pkg::BUSY_LIMIT_RST),
                        int'(clhg_pkg::SURGE_LIMIT_RST), int'(clhg_pkg::SURGE_STEP_RST),
                        int'(clhg_pkg::OFF_ROUNDS_RST), int'(clhg_pkg::ON_ROUNDS_RST));
        // large surge steps drive the busy score into saturation
        4: set_governor(2, 10, 20, 200, 3, 255);
        default: begin
          int il;
          int bl;
          il = $urandom_range(0, 40);
          bl = $urandom_range(il, 90);
          set_governor(il, bl, $urandom_range(bl, 100),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 8),
                       $urandom_range(1, 12), $urandom_range(1, 12));
        end
      endcase
      if (p == 1 || p == 5) begin
        gap_odds = 0;
        stall_odds = 0;
      end else begin
        gap_odds = $urandom_range(3, 10);
        stall_odds = $urandom_range(3, 10);
      end
      if (p == 3) hold_request = 1'b1;
      play_rounds(110, p == 2);
    end

    @(negedge clk);
    sample_ch.valid <= 1'b0;
    guard = 0;
    while (pending_rounds.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_rounds.size() != 0) begin
      $display("%0t %0d round results never arrived", $time, pending_rounds.size());
      fail_count += pending_rounds.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples over %0d register writes", samples_sent, settings_done);
    $display("checked %0d rounds: %0d offline and %0d online requests, %0d mismatches",
             rounds_checked, offline_seen, online_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
